/* rtl/ikset_pkg.sv */
// Shared types and constants for the indexed key set.
// Request/response structs, command codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ikset_pkg;

   localparam int WORD_W    = 64;
   localparam int KEY_W     = 4 * WORD_W;
   localparam int CMD_W     = 3;
   localparam int POS_W     = 6;
   localparam int CNT_OUT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 3'd0,
      CMD_CONTAINS   = 3'd1,
      CMD_REMOVE_KEY = 3'd2,
      CMD_GET        = 3'd3,
      CMD_REMOVE_POS = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_WR,
      ST_GET_DATA
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] key_word0;
      logic [WORD_W-1:0] key_word1;
      logic [WORD_W-1:0] key_word2;
      logic [WORD_W-1:0] key_word3;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic                 status;
      logic [WORD_W-1:0]    out_word0;
      logic [WORD_W-1:0]    out_word1;
      logic [WORD_W-1:0]    out_word2;
      logic [WORD_W-1:0]    out_word3;
      logic [POS_W-1:0]     found_position;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic hit;
   } scan_stat_type;

endpackage

`default_nettype wire

/* rtl/ikset_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ikset_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ikset_scan.sv */
// Key scan unit: walks the store one entry per cycle and compares
// each entry with the request key. Depends on ikset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ikset_scan #(
   parameter int CAPACITY = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            scan_run,
   input  wire logic [$clog2(CAPACITY+1)-1:0]   count,
   input  wire logic [ikset_pkg::KEY_W-1:0]     key,
   input  wire logic [ikset_pkg::KEY_W-1:0]     rd_data,
   output logic                                 rd_en,
   output logic      [$clog2(CAPACITY)-1:0]     rd_addr,
   output logic      [$clog2(CAPACITY)-1:0]     hit_idx,
   output ikset_pkg::scan_stat_type             stat
);
   import ikset_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          issue;
   logic          match;

   // data for cmp_idx_ff sits on the RAM output while cmp_vld_ff is set
   always_comb begin
      issue       = scan_run && (scan_idx_ff < count);
      match       = cmp_vld_ff && (rd_data == key);
      scan_idx_in = scan_run ? (issue ? scan_idx_ff + 1'b1 : scan_idx_ff) : '0;
      cmp_vld_in  = issue;
      cmp_idx_in  = scan_idx_ff[AW-1:0];
      rd_en       = issue;
      rd_addr     = scan_idx_ff[AW-1:0];
      hit_idx     = cmp_idx_ff;
      stat.hit    = scan_run && match;
      stat.done   = scan_run && (match || (!issue && !cmp_vld_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         cmp_vld_ff  <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

endmodule

`default_nettype wire

/* rtl/indexed_key_set.sv */
// Insert, contains and remove key scan the entries until a hit or the end; a remove that
// hits below the last entry then moves the last entry into the gap. Get reads, then answers;
// remove position also moves it unless it names the last; clear and bad requests answer from idle.
// Throughput: one request at a time; busy falls as the strobe rises, so the next
// request may start in that cycle. The scan reads one entry per cycle from one RAM port.
// Reset clears count and control state; stored keys are not cleared, results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module indexed_key_set #(
   parameter int CAPACITY = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ikset_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ikset_pkg::rsp_type     rsp_data
);
   import ikset_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [AW-1:0]    tgt_ff, tgt_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;

   logic             accept;
   logic [CW-1:0]    last;
   logic             pos_ok;
   logic [AW-1:0]    pos_addr;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;

   logic             scan_run;
   logic             scan_rd_en;
   logic [AW-1:0]    scan_rd_addr;
   logic [AW-1:0]    scan_hit_idx;
   scan_stat_type    scan_stat;

   ikset_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ikset_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_run (scan_run),
      .count    (count_ff),
      .key      (key_ff),
      .rd_data  (ram_rd_data),
      .rd_en    (scan_rd_en),
      .rd_addr  (scan_rd_addr),
      .hit_idx  (scan_hit_idx),
      .stat     (scan_stat)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = 1'b1;
      key_in       = key_ff;
      tgt_in       = tgt_ff;
      cmd_in       = cmd_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = key_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      scan_run     = 1'b0;
      last         = count_ff - 1'b1;
      pos_ok       = CMPW'(req_data.position) < CMPW'(count_ff);
      pos_addr     = AW'(req_data.position);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = {req_data.key_word3, req_data.key_word2,
                         req_data.key_word1, req_data.key_word0};
               cmd_in = req_data.command;
               case (req_data.command)
                  CMD_INSERT, CMD_CONTAINS, CMD_REMOVE_KEY: begin
                     state_in = ST_SCAN;
                  end
                  CMD_GET: begin
                     if (pos_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_addr;
                        state_in    = ST_GET_DATA;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_REMOVE_POS: begin
                     if (!pos_ok) begin
                        rsp_valid_in = 1'b1;
                     end else if (pos_addr == last[AW-1:0]) begin
                        count_in      = last;
                        rsp_in.status = 1'b0;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // fetch the last entry to fill the gap
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = last[AW-1:0];
                        tgt_in      = pos_addr;
                        state_in    = ST_MOVE_WR;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in      = '0;
                     rsp_in.status = 1'b0;
                     rsp_valid_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_run    = 1'b1;
            ram_rd_en   = scan_rd_en;
            ram_rd_addr = scan_rd_addr;
            if (scan_stat.done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (!scan_stat.hit && (count_ff < CW'(CAPACITY))) begin
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = count_ff[AW-1:0];
                        count_in      = count_ff + 1'b1;
                        rsp_in.status = 1'b0;
                     end
                  end
                  CMD_CONTAINS: begin
                     if (scan_stat.hit) begin
                        rsp_in.status         = 1'b0;
                        rsp_in.found_position = POS_W'(scan_hit_idx);
                     end
                  end
                  CMD_REMOVE_KEY: begin
                     if (scan_stat.hit) begin
                        if (scan_hit_idx == last[AW-1:0]) begin
                           count_in      = last;
                           rsp_in.status = 1'b0;
                        end else begin
                           // hold the response until the swap write
                           rsp_valid_in = 1'b0;
                           ram_rd_en    = 1'b1;
                           ram_rd_addr  = last[AW-1:0];
                           tgt_in       = scan_hit_idx;
                           state_in     = ST_MOVE_WR;
                        end
                     end
                  end
                  default: begin
                     rsp_in.status = 1'b1;
                  end
               endcase
            end
         end
         ST_MOVE_WR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = tgt_ff;
            ram_wr_data   = ram_rd_data;
            count_in      = last;
            rsp_in.status = 1'b0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_GET_DATA: begin
            rsp_in.status    = 1'b0;
            rsp_in.out_word0 = ram_rd_data[WORD_W-1:0];
            rsp_in.out_word1 = ram_rd_data[2*WORD_W-1:WORD_W];
            rsp_in.out_word2 = ram_rd_data[3*WORD_W-1:2*WORD_W];
            rsp_in.out_word3 = ram_rd_data[4*WORD_W-1:3*WORD_W];
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.entry_count = CNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tgt_ff <= tgt_in;
      cmd_ff <= cmd_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while sequencer busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted request neither in progress nor answered");

   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (count_ff == $past(count_ff)))
      else $error("failed request changed the entry count");
`endif

endmodule

`default_nettype wire
